@@ rtl/robin_hood_hash_table_core_macros.svh @@
// ----------------------------------------------------------------------------
// robin_hood_hash_table_core_macros
// Assertion helpers shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ROBIN_HOOD_HASH_TABLE_CORE_MACROS_SVH
`define ROBIN_HOOD_HASH_TABLE_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RHHT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define RHHT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

@@ rtl/rhht_pkg.sv @@
// ----------------------------------------------------------------------------
// rhht_pkg
// Beat types, operation codes and mixer constants for the hash table core.
// ----------------------------------------------------------------------------
package rhht_pkg;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [63:0] key;
      logic [63:0]        value;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [63:0] read_value;
      logic        status;
      logic [10:0] entry_count;
   } rsp_type;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_SET    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [10:0] FILL_LIMIT_RESET = 11'd768;

   localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;
   localparam int MIX_SHIFT_A = 30;
   localparam int MIX_SHIFT_B = 27;
   localparam int MIX_SHIFT_C = 31;

endpackage

@@ rtl/robin_hood_hash_table_core.sv @@
// After a request is accepted the key is mixed (ST_HASH); each slot visited by a probe
// then takes a memory read and an evaluate-and-write-back step, and the response beat
// is posted last, once no earlier beat is held by rsp_stall. One item at a time: no
// new request is accepted until the beat is posted; a new key adds a placement walk
// and a remove adds one per following entry. Reset is synchronous; a sweep then
// clears the slots, req_stall high.
// ----------------------------------------------------------------------------
// robin_hood_hash_table_core
// Robin Hood linear-probe key/value table with lookup, set and remove.
// ----------------------------------------------------------------------------
module robin_hood_hash_table_core #(
   parameter int CAPACITY = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rhht_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rhht_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [10:0]      csr_wr_data
);
   import rhht_pkg::*;

   localparam int D    = $clog2(CAPACITY);
   localparam int CW   = D + 1;
   localparam int EW   = 1 + D + 128;
   localparam int CMPW = (CW > 11) ? CW : 11;

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_HASH   = 4'd2;
   localparam logic [3:0] ST_LOC_RD = 4'd3;
   localparam logic [3:0] ST_LOC_EV = 4'd4;
   localparam logic [3:0] ST_PLC_RD = 4'd5;
   localparam logic [3:0] ST_PLC_EV = 4'd6;
   localparam logic [3:0] ST_REM_RD = 4'd7;
   localparam logic [3:0] ST_REM_EV = 4'd8;
   localparam logic [3:0] ST_RESP   = 4'd9;

   localparam logic [CW-1:0] CNT_LAST = CW'(CAPACITY - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(CAPACITY);

   logic [3:0]    state_ff, state_in;
   logic [1:0]    op_ff, op_in;
   logic [63:0]   key_ff, key_in;
   logic [63:0]   val_ff, val_in;
   logic [D-1:0]  idx_ff, idx_in;
   logic [CW-1:0] dist_ff, dist_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [D-1:0]  rem_idx_ff, rem_idx_in;
   logic [CW-1:0] rem_n_ff, rem_n_in;
   logic          plc_rem_ff, plc_rem_in;
   logic [CW-1:0] count_ff, count_in;
   logic [10:0]   fill_limit_ff;
   logic          found_ff, found_in;
   logic [63:0]   rdv_ff, rdv_in;
   logic          status_ff, status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          mix_start, mix_done;
   logic [63:0]   mixed;

   logic          mem_we;
   logic [D-1:0]  mem_waddr, mem_raddr;
   logic [EW-1:0] mem_wdata, mem_rdata;

   logic          rd_used;
   logic [D-1:0]  rd_dist;
   logic [63:0]   rd_key, rd_val;
   logic          accept;
   logic          refuse;
   logic          dist_gt;
   logic          plc_done;

   assign rd_used = mem_rdata[EW-1];
   assign rd_dist = mem_rdata[EW-2 -: D];
   assign rd_key  = mem_rdata[127:64];
   assign rd_val  = mem_rdata[63:0];

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign mix_start = accept;
   assign mem_raddr = (state_ff == ST_REM_RD || state_ff == ST_REM_EV) ? rem_idx_ff : idx_ff;
   assign dist_gt   = dist_ff > CW'(rd_dist);
   assign refuse    = (CMPW'(count_ff) >= CMPW'(fill_limit_ff)) || (count_ff >= CNT_FULL);

   rhht_mix u_mix (
      .clock (clock),
      .reset (reset),
      .start (mix_start),
      .key   (req_data.key),
      .done  (mix_done),
      .mixed (mixed)
   );

   rhht_slot_mem #(
      .WIDTH (EW),
      .DEPTH (CAPACITY)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      idx_in       = idx_ff;
      dist_in      = dist_ff;
      cnt_in       = cnt_ff;
      rem_idx_in   = rem_idx_ff;
      rem_n_in     = rem_n_ff;
      plc_rem_in   = plc_rem_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      rdv_in       = rdv_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_wdata    = '0;
      plc_done     = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            // sweep the occupied marks, one slot per cycle
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            idx_in    = idx_ff + D'(1);
            if (idx_ff == D'(CAPACITY - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in     = req_data.operation;
               key_in    = req_data.key;
               val_in    = req_data.value;
               found_in  = 1'b0;
               rdv_in    = '0;
               status_in = 1'b0;
               if (req_data.operation == OP_LOOKUP || req_data.operation == OP_SET ||
                   req_data.operation == OP_REMOVE) begin
                  state_in = ST_HASH;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_HASH: begin
            if (mix_done) begin
               idx_in   = mixed[D-1:0];
               dist_in  = '0;
               cnt_in   = '0;
               state_in = ST_LOC_RD;
            end
         end
         ST_LOC_RD: begin
            state_in = ST_LOC_EV;
         end
         ST_LOC_EV: begin
            if (rd_used && rd_key == key_ff) begin
               found_in = 1'b1;
               case (op_ff)
                  OP_LOOKUP: begin
                     rdv_in   = rd_val;
                     state_in = ST_RESP;
                  end
                  OP_SET: begin
                     mem_we    = 1'b1;
                     mem_wdata = {mem_rdata[EW-1:64], val_ff};
                     state_in  = ST_RESP;
                  end
                  default: begin
                     // drop the entry, then lift out the run that follows
                     mem_we     = 1'b1;
                     mem_wdata  = '0;
                     if (count_ff != '0) begin
                        count_in = count_ff - CW'(1);
                     end
                     rem_idx_in = idx_ff + D'(1);
                     rem_n_in   = '0;
                     state_in   = ST_REM_RD;
                  end
               endcase
            end else if (!rd_used || dist_gt || cnt_ff == CNT_LAST) begin
               // miss
               if (op_ff == OP_SET) begin
                  if (refuse) begin
                     status_in = 1'b1;
                     state_in  = ST_RESP;
                  end else begin
                     count_in   = count_ff + CW'(1);
                     idx_in     = mixed[D-1:0];
                     dist_in    = '0;
                     cnt_in     = '0;
                     plc_rem_in = 1'b0;
                     state_in   = ST_PLC_RD;
                  end
               end else begin
                  state_in = ST_RESP;
               end
            end else begin
               idx_in   = idx_ff + D'(1);
               dist_in  = dist_ff + CW'(1);
               cnt_in   = cnt_ff + CW'(1);
               state_in = ST_LOC_RD;
            end
         end
         ST_PLC_RD: begin
            state_in = ST_PLC_EV;
         end
         ST_PLC_EV: begin
            if (!rd_used) begin
               mem_we    = 1'b1;
               mem_wdata = {1'b1, dist_ff[D-1:0], key_ff, val_ff};
               plc_done  = 1'b1;
            end else if (rd_key == key_ff) begin
               mem_we    = 1'b1;
               mem_wdata = {mem_rdata[EW-1:64], val_ff};
               plc_done  = 1'b1;
            end else if (dist_gt) begin
               // swap with the resident closer to its home, carry it onward
               mem_we    = 1'b1;
               mem_wdata = {1'b1, dist_ff[D-1:0], key_ff, val_ff};
               key_in    = rd_key;
               val_in    = rd_val;
               dist_in   = CW'(rd_dist) + CW'(1);
            end else begin
               dist_in = dist_ff + CW'(1);
            end
            idx_in = idx_ff + D'(1);
            cnt_in = cnt_ff + CW'(1);
            if (plc_done || cnt_ff == CNT_LAST) begin
               if (plc_rem_ff && rem_n_ff != CNT_FULL) begin
                  state_in = ST_REM_RD;
               end else begin
                  state_in = ST_RESP;
               end
            end else begin
               state_in = ST_PLC_RD;
            end
         end
         ST_REM_RD: begin
            state_in = ST_REM_EV;
         end
         ST_REM_EV: begin
            if (!rd_used) begin
               state_in = ST_RESP;
            end else begin
               mem_we     = 1'b1;
               mem_waddr  = rem_idx_ff;
               mem_wdata  = '0;
               key_in     = rd_key;
               val_in     = rd_val;
               idx_in     = rem_idx_ff - rd_dist;
               dist_in    = '0;
               cnt_in     = '0;
               plc_rem_in = 1'b1;
               rem_idx_in = rem_idx_ff + D'(1);
               rem_n_in   = rem_n_ff + CW'(1);
               state_in   = ST_PLC_RD;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in.found       = found_ff;
               rsp_in.read_value  = rdv_ff;
               rsp_in.status      = status_ff;
               rsp_in.entry_count = 11'(count_ff);
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_in_hold: begin
         op_ff      <= op_in;
         key_ff     <= key_in;
         val_ff     <= val_in;
         dist_ff    <= dist_in;
         cnt_ff     <= cnt_in;
         rem_idx_ff <= rem_idx_in;
         rem_n_ff   <= rem_n_in;
         plc_rem_ff <= plc_rem_in;
         found_ff   <= found_in;
         rdv_ff     <= rdv_in;
         status_ff  <= status_in;
         rsp_ff     <= rsp_in;
      end
      if (reset) begin
         state_ff      <= ST_CLEAR;
         idx_ff        <= '0;
         count_ff      <= '0;
         fill_limit_ff <= FILL_LIMIT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            fill_limit_ff <= csr_wr_data;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`include "robin_hood_hash_table_core_macros.svh"

   `RHHT_ASSERT(a_count_bound, count_ff <= CNT_FULL, "entry count above capacity")
   `RHHT_ASSERT(a_accept_leaves_idle, accept |=> (state_ff != ST_IDLE), "accepted beat not started")
   `RHHT_ASSERT(a_full_not_found, rsp_valid_ff |-> !(rsp_ff.found && rsp_ff.status), "full reported on a hit")
   `RHHT_ASSERT(a_count_step, ##1 (count_ff == $past(count_ff) || count_ff == $past(count_ff) + CW'(1) || count_ff == $past(count_ff) - CW'(1)), "entry count jumped")
   `RHHT_ASSERT_ALWAYS(a_reset_clears, reset |=> (state_ff == ST_CLEAR && !rsp_valid_ff), "reset did not start clear sweep")

endmodule

@@ rtl/rhht_mix.sv @@
// ----------------------------------------------------------------------------
// rhht_mix
// Multi-cycle 64-bit finalizer: two 64x64 low-half products built from a
// shared 32x32 multiplier, three partial products each.
// ----------------------------------------------------------------------------
module rhht_mix (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] key,
   output logic        done,
   output logic [63:0] mixed
);
   import rhht_pkg::*;

   logic [63:0] a_ff, a_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] res_ff, res_in;
   logic [2:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   logic [63:0] mul_c;
   logic [1:0]  sub;
   logic [31:0] mul_x, mul_y;
   logic [63:0] prod, addend;

   always_comb begin
      mul_c  = step_ff[2] ? MIX_MUL_B : MIX_MUL_A;
      sub    = step_ff[1:0];
      mul_x  = (sub == 2'd1) ? a_ff[63:32] : a_ff[31:0];
      mul_y  = (sub == 2'd2) ? mul_c[63:32] : mul_c[31:0];
      prod   = 64'(mul_x) * 64'(mul_y);
      addend = (sub == 2'd0) ? prod : {prod[31:0], 32'd0};
   end

   always_comb begin
      a_in    = a_ff;
      acc_in  = acc_ff;
      res_in  = res_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = key ^ (key >> MIX_SHIFT_A);
         step_in = 3'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         step_in = step_ff + 3'd1;
         case (sub)
            2'd0: acc_in = addend;
            2'd1, 2'd2: acc_in = acc_ff + addend;
            default: begin
               if (step_ff[2]) begin
                  res_in  = acc_ff ^ (acc_ff >> MIX_SHIFT_C);
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  a_in = acc_ff ^ (acc_ff >> MIX_SHIFT_B);
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done  = done_ff;
   assign mixed = res_ff;

endmodule

@@ rtl/rhht_slot_mem.sv @@
// ----------------------------------------------------------------------------
// rhht_slot_mem
// Simple dual-port slot memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rhht_slot_mem #(
   parameter int WIDTH = 139,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ tb/sv/robin_hood_hash_table_core_test.sv @@
// ----------------------------------------------------------------------------
// robin_hood_hash_table_core_test
// Drives lookups, sets, removes and no-op beats into the hash table core, mirrors
// the table in a scoreboard and checks every response beat field by field.
// ----------------------------------------------------------------------------
module robin_hood_hash_table_core_test;
   import rhht_pkg::*;

   localparam int SLOTS = 1024;

   class table_scoreboard;
      bit [63:0] slot_key[SLOTS];
      bit [63:0] slot_val[SLOTS];
      bit        slot_used[SLOTS];
      int        slot_dist[SLOTS];
      int        count;
      int        limit;
      rsp_type   expected_rsp[$];
      int        failures;

      function new();
         count = 0;
         limit = FILL_LIMIT_RESET;
         failures = 0;
         foreach (slot_used[i]) slot_used[i] = 0;
      endfunction

      static function int home(bit [63:0] k);
         bit [63:0] v;
         v = k;
         v ^= v >> MIX_SHIFT_A;
         v = v * MIX_MUL_A;
         v ^= v >> MIX_SHIFT_B;
         v = v * MIX_MUL_B;
         v ^= v >> MIX_SHIFT_C;
         return int'(v[9:0]);
      endfunction

      function bit find_slot(bit [63:0] k, output int at);
         int idx;
         int d;
         idx = home(k);
         at = 0;
         for (d = 0; d < SLOTS; d++) begin
            if (!slot_used[idx]) return 0;
            if (slot_key[idx] == k) begin
               at = idx;
               return 1;
            end
            if (d > slot_dist[idx]) return 0;
            idx = (idx + 1) % SLOTS;
         end
         return 0;
      endfunction

      function void place(bit [63:0] k, bit [63:0] v);
         int idx;
         int d;
         int n;
         bit [63:0] tk;
         bit [63:0] tv;
         int td;
         idx = home(k);
         d = 0;
         for (n = 0; n < SLOTS; n++) begin
            if (!slot_used[idx]) begin
               slot_key[idx] = k;
               slot_val[idx] = v;
               slot_used[idx] = 1;
               slot_dist[idx] = d;
               return;
            end
            if (slot_key[idx] == k) begin
               slot_val[idx] = v;
               return;
            end
            if (d > slot_dist[idx]) begin
               tk = slot_key[idx];
               tv = slot_val[idx];
               td = slot_dist[idx];
               slot_key[idx] = k;
               slot_val[idx] = v;
               slot_dist[idx] = d;
               k = tk;
               v = tv;
               d = td;
            end
            idx = (idx + 1) % SLOTS;
            d++;
         end
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         int at;
         int idx;
         int n;
         e = '0;
         case (r.operation)
            OP_LOOKUP: begin
               if (find_slot(r.key, at)) begin
                  e.found = 1;
                  e.read_value = slot_val[at];
               end
            end
            OP_SET: begin
               if (find_slot(r.key, at)) begin
                  e.found = 1;
                  slot_val[at] = r.value;
               end else if (count >= limit || count >= SLOTS) begin
                  e.status = 1;
               end else begin
                  place(r.key, r.value);
                  count++;
               end
            end
            OP_REMOVE: begin
               if (find_slot(r.key, at)) begin
                  e.found = 1;
                  slot_used[at] = 0;
                  if (count > 0) count--;
                  idx = at;
                  // lift out and re-place the rest of the cluster
                  for (n = 0; n < SLOTS; n++) begin
                     idx = (idx + 1) % SLOTS;
                     if (!slot_used[idx]) break;
                     slot_used[idx] = 0;
                     place(slot_key[idx], slot_val[idx]);
                  end
               end
            end
            default: ;
         endcase
         e.entry_count = count[10:0];
         expected_rsp.push_back(e);
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (expected_rsp.size() == 0) begin
            $error("response beat with nothing expected: %h", got);
            failures++;
            return;
         end
         e = expected_rsp.pop_front();
         if (got.found !== e.found) begin
            $error("found: expected %0d, actual %0d", e.found, got.found);
            failures++;
         end
         if (got.read_value !== e.read_value) begin
            $error("read_value: expected %h, actual %h", e.read_value, got.read_value);
            failures++;
         end
         if (got.status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, got.status);
            failures++;
         end
         if (got.entry_count !== e.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", e.entry_count,
                   got.entry_count);
            failures++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_wr_en;
   logic [10:0] csr_wr_data;

   table_scoreboard sb;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          hold_cycles;
   bit [63:0]   key_pool[$];

   robin_hood_hash_table_core #(.CAPACITY(SLOTS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // response side: sample at the rising edge, pick the stall at the falling edge
   initial begin
      rsp_stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall = 1;
            hold_cycles--;
         end else begin
            rsp_stall = ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   task automatic send_beat(bit [1:0] op, bit [63:0] k, bit [63:0] v);
      req_type r;
      r.operation = op;
      r.key = k;
      r.value = v;
      req_data = r;
      req_valid = 1;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid = 0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
   endtask

   task automatic write_limit(bit [10:0] lim);
      req_valid = 0;
      while (sb.expected_rsp.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_wr_en = 1;
      csr_wr_data = lim;
      @(negedge clock);
      csr_wr_en = 0;
      sb.limit = lim;
   endtask

   task automatic random_beats(int n);
      bit [1:0]  op;
      bit [63:0] k;
      int        pick;
      repeat (n) begin
         pick = $urandom_range(99);
         if (pick < 45) op = OP_SET;
         else if (pick < 70) op = OP_LOOKUP;
         else if (pick < 95) op = OP_REMOVE;
         else op = OP_NONE;
         if ($urandom_range(99) < 85) k = key_pool[$urandom_range(key_pool.size() - 1)];
         else k = {$urandom, $urandom};
         send_beat(op, k, {$urandom, $urandom});
      end
   endtask

   initial begin
      bit [63:0] k;
      sb = new();
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_wr_en = 0;
      csr_wr_data = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles = 0;
      // clustered keys: homes near slot 0 and at the wrap point
      while (key_pool.size() < 24) begin
         k = {$urandom, $urandom};
         if (table_scoreboard::home(k) < 6) key_pool.push_back(k);
      end
      while (key_pool.size() < 36) begin
         k = {$urandom, $urandom};
         if (table_scoreboard::home(k) > 1019) key_pool.push_back(k);
      end
      repeat (12) key_pool.push_back({$urandom, $urandom});
      key_pool.push_back(64'h8000_0000_0000_0000);
      key_pool.push_back(64'h7fff_ffff_ffff_ffff);
      key_pool.push_back(64'h0);
      key_pool.push_back(64'hffff_ffff_ffff_ffff);
      repeat (11) @(negedge clock);
      reset = 0;

      // directed: limit of one, then zero
      write_limit(11'd1);
      send_beat(OP_SET, 64'h8000_0000_0000_0000, 64'hffff_ffff_ffff_ffff);
      send_beat(OP_SET, 64'h7fff_ffff_ffff_ffff, 64'h1);
      send_beat(OP_LOOKUP, 64'h8000_0000_0000_0000, 64'h0);
      send_beat(OP_SET, 64'h8000_0000_0000_0000, 64'h0);
      send_beat(OP_LOOKUP, 64'h8000_0000_0000_0000, 64'hffff_ffff_ffff_ffff);
      send_beat(OP_NONE, 64'h8000_0000_0000_0000, 64'h5);
      send_beat(OP_REMOVE, 64'h7fff_ffff_ffff_ffff, 64'h0);
      send_beat(OP_REMOVE, 64'h8000_0000_0000_0000, 64'h0);
      send_beat(OP_LOOKUP, 64'h8000_0000_0000_0000, 64'h0);
      write_limit(11'd0);
      send_beat(OP_SET, 64'h0, 64'h1234);
      write_limit(11'd2047);
      // fill a cluster, then break it up: early stop, swaps and wrap
      for (int i = 0; i < 8; i++) send_beat(OP_SET, key_pool[i * 4 % 36], {$urandom, $urandom});
      send_beat(OP_LOOKUP, {$urandom, $urandom}, 64'h0);
      send_beat(OP_REMOVE, key_pool[0], 64'h0);
      send_beat(OP_LOOKUP, key_pool[4], 64'h0);
      send_beat(OP_REMOVE, key_pool[28], 64'h0);
      send_beat(OP_LOOKUP, key_pool[32], 64'h0);

      send_idle_pct = 10;
      recv_idle_pct = 53;
      random_beats(380);
      write_limit(11'd20);
      send_idle_pct = 53;
      recv_idle_pct = 10;
      random_beats(380);
      write_limit(11'd1024);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles = 400;
      random_beats(370);
      write_limit(FILL_LIMIT_RESET);
      random_beats(20);

      req_valid = 0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.failures == 0 && sb.expected_rsp.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
